FILE: sv/unix_seconds_to_calendar_defines.svh
// Assertion macros shared by the calendar converter RTL.
`ifndef UNIX_SECONDS_TO_CALENDAR_DEFINES_SVH
`define UNIX_SECONDS_TO_CALENDAR_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while in reset.
`define UCAL_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication after a fixed number of cycles.
`define UCAL_ASSERT_DELAY(lbl, ante, n, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(n) (cons)) \
        else $error(msg);

`endif

FILE: sv/ucal_pkg.sv
// Types, constants and tables for the Unix time to calendar converter.
package ucal_pkg;

    // Working widths
    localparam int U_W    = 37;  // seconds since 0000-01-01 inside the valid span
    localparam int LO_W   = 7;   // 86400 = 2^7 * 675
    localparam int X_W    = 30;  // U_W - LO_W
    localparam int DAY_W  = 21;
    localparam int SOD_W  = 17;
    localparam int DOE_W  = 18;
    localparam int YOE_W  = 9;
    localparam int DOY_W  = 9;
    localparam int ERA_W  = 4;
    localparam int WQ_W   = 19;

    // Valid span: 0000-01-01 00:00:00 .. 4095-12-31 23:59:59
    localparam logic signed [63:0] SECS_MIN = -64'sd62167219200;
    localparam logic signed [63:0] SECS_MAX = 64'sd67090118399;

    // Reciprocal multipliers and shifts (exact over the operand widths used)
    localparam logic [30:0] MUL_675   = 31'd1628906116;  // x / 675, shift 40
    localparam int          SH_675    = 40;
    localparam logic [9:0]  DIV_675   = 10'd675;
    localparam logic [17:0] MUL_3600  = 18'd149131;      // shift 29
    localparam int          SH_3600   = 29;
    localparam logic [16:0] SECS_HOUR = 17'd3600;
    localparam logic [12:0] MUL_60    = 13'd4370;        // shift 18
    localparam int          SH_60     = 18;
    localparam logic [11:0] SECS_MIN_UNIT = 12'd60;
    localparam logic [21:0] MUL_ERA   = 22'd3762951;     // x / 146097, shift 39
    localparam int          SH_ERA    = 39;
    localparam logic [21:0] MUL_WEEK  = 22'd2396746;     // x / 7, shift 24
    localparam int          SH_WEEK   = 24;
    localparam logic [18:0] MUL_1460  = 19'd367720;      // shift 29
    localparam int          SH_1460   = 29;
    localparam logic [18:0] MUL_365   = 19'd367720;      // shift 27
    localparam int          SH_365    = 27;
    localparam logic [9:0]  MUL_100   = 10'd656;         // shift 16
    localparam int          SH_100    = 16;
    localparam logic [11:0] MUL_153   = 12'd3427;        // shift 19
    localparam int          SH_153    = 19;

    // Calendar constants
    localparam logic [DAY_W-1:0] Z_OFFSET  = 21'd146037;  // one era less 60 days
    localparam logic [DAY_W-1:0] WD_OFFSET = 21'd6;       // 0000-01-01 was a Saturday
    localparam logic [17:0]      DAYS_ERA  = 18'd146097;
    localparam logic [17:0]      DAYS_CENT = 18'd36524;
    localparam logic [17:0]      DAYS_YEAR = 18'd365;
    localparam logic [21:0]      WEEK_DAYS = 22'd7;
    localparam logic [12:0]      YEARS_ERA = 13'd400;

    // Pipeline depths
    localparam int SPLIT_LAT = 3;
    localparam int TOD_LAT   = 4;
    localparam int CIVIL_LAT = 10;
    localparam int TOD_PAD   = CIVIL_LAT - TOD_LAT;
    localparam int TOTAL_LAT = SPLIT_LAT + CIVIL_LAT + 1;

    typedef struct packed {
        logic valid;
        logic in_range;
    } ucal_ctl_t;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } ucal_tod_t;

    typedef struct packed {
        logic [2:0]  weekday;
        logic [4:0]  day_of_month;
        logic [3:0]  month;
        logic [11:0] year;
    } ucal_date_t;

    // First day of each March-based month within the year
    function automatic logic [DOY_W-1:0] month_start(input logic [3:0] mp);
        logic [DOY_W-1:0] s;
        case (mp)
            4'd0:    s = 9'd0;
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd61;
            4'd3:    s = 9'd92;
            4'd4:    s = 9'd122;
            4'd5:    s = 9'd153;
            4'd6:    s = 9'd184;
            4'd7:    s = 9'd214;
            4'd8:    s = 9'd245;
            4'd9:    s = 9'd275;
            4'd10:   s = 9'd306;
            4'd11:   s = 9'd337;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

endpackage

FILE: sv/ucal_split.sv
// Range check and split of signed seconds into day number and second of day.
module ucal_split #(
    parameter int TIME_WIDTH = 40
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [TIME_WIDTH-1:0]         epoch_secs,
    output ucal_pkg::ucal_ctl_t           ctl,
    output logic [ucal_pkg::DAY_W-1:0]    day,
    output logic [ucal_pkg::SOD_W-1:0]    sod
);

    localparam logic [TIME_WIDTH-1:0] SMIN = ucal_pkg::SECS_MIN[TIME_WIDTH-1:0];
    localparam logic [TIME_WIDTH-1:0] SMAX = ucal_pkg::SECS_MAX[TIME_WIDTH-1:0];
    localparam int PROD_W = ucal_pkg::X_W + 31;

    ucal_pkg::ucal_ctl_t ctl_next;
    ucal_pkg::ucal_ctl_t a_ctl_reg;
    ucal_pkg::ucal_ctl_t b_ctl_reg;
    ucal_pkg::ucal_ctl_t c_ctl_reg;

    logic [TIME_WIDTH-1:0]         diff;
    logic [ucal_pkg::U_W-1:0]      a_u_reg;
    logic [PROD_W-1:0]             day_prod;
    logic [ucal_pkg::DAY_W-1:0]    b_day_reg;
    logic [ucal_pkg::X_W-1:0]      b_x_reg;
    logic [ucal_pkg::LO_W-1:0]     b_lo_reg;
    logic [30:0]                   day_back;
    logic [ucal_pkg::X_W-1:0]      rem_full;
    logic [ucal_pkg::DAY_W-1:0]    c_day_reg;
    logic [ucal_pkg::SOD_W-1:0]    c_sod_reg;
    logic [ucal_pkg::SOD_W-1:0]    sod_next;

    // Input: range check, rebase to seconds since 0000-01-01
    always_comb
    begin
        ctl_next.valid    = in_valid;
        ctl_next.in_range = ($signed(epoch_secs) >= $signed(SMIN)) &&
                            ($signed(epoch_secs) <= $signed(SMAX));
        diff              = epoch_secs - SMIN;
    end

    // Stage B: day = (u >> 7) / 675 by reciprocal
    assign day_prod = PROD_W'(a_u_reg[ucal_pkg::U_W-1:ucal_pkg::LO_W]) *
                      PROD_W'(ucal_pkg::MUL_675);

    // Stage C: remainder rebuilt into second of day
    always_comb
    begin
        day_back = 31'(b_day_reg) * 31'(ucal_pkg::DIV_675);
        rem_full = b_x_reg - day_back[ucal_pkg::X_W-1:0];
        sod_next = {rem_full[9:0], b_lo_reg};
    end

    // Control travels with the word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_ctl_reg <= '0;
            b_ctl_reg <= '0;
            c_ctl_reg <= '0;
        end
        else
        begin
            a_ctl_reg <= ctl_next;
            b_ctl_reg <= a_ctl_reg;
            c_ctl_reg <= b_ctl_reg;
        end
    end

    // Data path registers
    always_ff @(posedge clk)
    begin
        a_u_reg   <= diff[ucal_pkg::U_W-1:0];
        b_day_reg <= day_prod[ucal_pkg::SH_675 +: ucal_pkg::DAY_W];
        b_x_reg   <= a_u_reg[ucal_pkg::U_W-1:ucal_pkg::LO_W];
        b_lo_reg  <= a_u_reg[ucal_pkg::LO_W-1:0];
        c_day_reg <= b_day_reg;
        c_sod_reg <= sod_next;
    end

    assign ctl = c_ctl_reg;
    assign day = c_day_reg;
    assign sod = c_sod_reg;

endmodule

FILE: sv/ucal_tod.sv
// Hour, minute and second from the second of the day.
module ucal_tod (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [ucal_pkg::SOD_W-1:0]  sod,
    output logic                        out_valid,
    output ucal_pkg::ucal_tod_t         tod
);

    typedef struct packed {
        logic [ucal_pkg::SOD_W-1:0] sod;
        logic [4:0]                 hour;
        logic [11:0]                rest;
        logic [5:0]                 minute;
        logic [5:0]                 second;
    } tod_st_t;

    localparam int NST = ucal_pkg::TOD_LAT;

    logic [NST-1:0] valid_reg;
    tod_st_t        st_reg  [NST];
    tod_st_t        st_next [NST];

    logic [34:0]    hour_prod;
    logic [16:0]    hour_back;
    logic [16:0]    rest_full;
    logic [24:0]    min_prod;
    logic [11:0]    min_back;
    logic [11:0]    sec_full;

    // T1: hour by reciprocal of 3600
    always_comb
    begin
        st_next[0]      = '0;
        st_next[0].sod  = sod;
        hour_prod       = 35'(sod) * 35'(ucal_pkg::MUL_3600);
        st_next[0].hour = hour_prod[ucal_pkg::SH_3600 +: 5];
    end

    // T2: seconds left in the hour
    always_comb
    begin
        st_next[1]      = st_reg[0];
        hour_back       = 17'(st_reg[0].hour) * ucal_pkg::SECS_HOUR;
        rest_full       = st_reg[0].sod - hour_back;
        st_next[1].rest = rest_full[11:0];
    end

    // T3: minute by reciprocal of 60
    always_comb
    begin
        st_next[2]        = st_reg[1];
        min_prod          = 25'(st_reg[1].rest) * 25'(ucal_pkg::MUL_60);
        st_next[2].minute = min_prod[ucal_pkg::SH_60 +: 6];
    end

    // T4: second
    always_comb
    begin
        st_next[3]        = st_reg[2];
        min_back          = 12'(st_reg[2].minute) * ucal_pkg::SECS_MIN_UNIT;
        sec_full          = st_reg[2].rest - min_back;
        st_next[3].second = sec_full[5:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[NST-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NST; i++)
        begin
            st_reg[i] <= st_next[i];
        end
    end

    assign out_valid  = valid_reg[NST-1];
    assign tod.hour   = st_reg[NST-1].hour;
    assign tod.minute = st_reg[NST-1].minute;
    assign tod.second = st_reg[NST-1].second;

endmodule

FILE: sv/ucal_civil.sv
// Day number to weekday, year, month and day by 400-year eras.
module ucal_civil (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ucal_pkg::ucal_ctl_t         ctl_in,
    input  logic [ucal_pkg::DAY_W-1:0]  day,
    output ucal_pkg::ucal_ctl_t         ctl_out,
    output ucal_pkg::ucal_date_t        date
);

    typedef struct packed {
        logic [ucal_pkg::DAY_W-1:0] z;
        logic [ucal_pkg::DAY_W-1:0] w;
        logic [ucal_pkg::ERA_W-1:0] era;
        logic [ucal_pkg::WQ_W-1:0]  wq;
        logic [ucal_pkg::DOE_W-1:0] doe;
        logic [2:0]                 wd;
        logic [6:0]                 q1460;
        logic [2:0]                 qcent;
        logic                       last_day;
        logic [ucal_pkg::DOE_W-1:0] t;
        logic [ucal_pkg::YOE_W-1:0] yoe;
        logic [17:0]                yoe_days;
        logic [1:0]                 q100;
        logic [ucal_pkg::DOY_W-1:0] doy;
        logic [3:0]                 mp;
    } civ_st_t;

    localparam int NST = ucal_pkg::CIVIL_LAT - 1;

    ucal_pkg::ucal_ctl_t ctl_reg [ucal_pkg::CIVIL_LAT];
    civ_st_t             st_reg  [NST];
    civ_st_t             st_next [NST];
    ucal_pkg::ucal_date_t date_reg;
    ucal_pkg::ucal_date_t date_next;

    logic [42:0] era_prod;
    logic [42:0] wq_prod;
    logic [21:0] era_back;
    logic [21:0] doe_full;
    logic [21:0] wd_full;
    logic [36:0] q1460_prod;
    logic [36:0] yoe_prod;
    logic [18:0] q100_prod;
    logic [17:0] yoe_sub;
    logic [17:0] doy_full;
    logic [10:0] mp_arg;
    logic [22:0] mp_prod;
    logic [ucal_pkg::DOY_W-1:0] dom_full;
    logic [3:0]  mon;
    logic [12:0] year_full;

    // C1: shift day number into the era frame and the week frame
    always_comb
    begin
        st_next[0]   = '0;
        st_next[0].z = day + ucal_pkg::Z_OFFSET;
        st_next[0].w = day + ucal_pkg::WD_OFFSET;
    end

    // C2: era and week count by reciprocal
    always_comb
    begin
        st_next[1]     = st_reg[0];
        era_prod       = 43'(st_reg[0].z) * 43'(ucal_pkg::MUL_ERA);
        wq_prod        = 43'(st_reg[0].w) * 43'(ucal_pkg::MUL_WEEK);
        st_next[1].era = era_prod[ucal_pkg::SH_ERA +: ucal_pkg::ERA_W];
        st_next[1].wq  = wq_prod[ucal_pkg::SH_WEEK +: ucal_pkg::WQ_W];
    end

    // C3: day of era and weekday
    always_comb
    begin
        st_next[2]     = st_reg[1];
        era_back       = 22'(st_reg[1].era) * 22'(ucal_pkg::DAYS_ERA);
        doe_full       = 22'(st_reg[1].z) - era_back;
        wd_full        = 22'(st_reg[1].w) - 22'(st_reg[1].wq) * ucal_pkg::WEEK_DAYS;
        st_next[2].doe = doe_full[ucal_pkg::DOE_W-1:0];
        st_next[2].wd  = wd_full[2:0];
    end

    // C4: leap corrections: doe/1460, doe/36524, doe/146096
    always_comb
    begin
        st_next[3]          = st_reg[2];
        q1460_prod          = 37'(st_reg[2].doe) * 37'(ucal_pkg::MUL_1460);
        st_next[3].q1460    = q1460_prod[ucal_pkg::SH_1460 +: 7];
        st_next[3].qcent    = 3'(st_reg[2].doe >= ucal_pkg::DAYS_CENT)
                            + 3'(st_reg[2].doe >= 18'(ucal_pkg::DAYS_CENT * 2))
                            + 3'(st_reg[2].doe >= 18'(ucal_pkg::DAYS_CENT * 3))
                            + 3'(st_reg[2].doe >= 18'(ucal_pkg::DAYS_ERA - 1));
        st_next[3].last_day = (st_reg[2].doe == 18'(ucal_pkg::DAYS_ERA - 1));
    end

    // C5: day count with leap days taken out
    always_comb
    begin
        st_next[4]   = st_reg[3];
        st_next[4].t = st_reg[3].doe - 18'(st_reg[3].q1460) + 18'(st_reg[3].qcent)
                     - 18'(st_reg[3].last_day);
    end

    // C6: year of era
    always_comb
    begin
        st_next[5]     = st_reg[4];
        yoe_prod       = 37'(st_reg[4].t) * 37'(ucal_pkg::MUL_365);
        st_next[5].yoe = yoe_prod[ucal_pkg::SH_365 +: ucal_pkg::YOE_W];
    end

    // C7: days in whole years, century correction
    always_comb
    begin
        st_next[6]          = st_reg[5];
        st_next[6].yoe_days = 18'(st_reg[5].yoe) * ucal_pkg::DAYS_YEAR;
        q100_prod           = 19'(st_reg[5].yoe) * 19'(ucal_pkg::MUL_100);
        st_next[6].q100     = q100_prod[ucal_pkg::SH_100 +: 2];
    end

    // C8: day of March-based year
    always_comb
    begin
        st_next[7]     = st_reg[6];
        yoe_sub        = st_reg[6].yoe_days + 18'(st_reg[6].yoe >> 2) - 18'(st_reg[6].q100);
        doy_full       = st_reg[6].doe - yoe_sub;
        st_next[7].doy = doy_full[ucal_pkg::DOY_W-1:0];
    end

    // C9: March-based month index (5*doy + 2) / 153
    always_comb
    begin
        st_next[8]    = st_reg[7];
        mp_arg        = 11'({st_reg[7].doy, 2'b00}) + 11'(st_reg[7].doy) + 11'd2;
        mp_prod       = 23'(mp_arg) * 23'(ucal_pkg::MUL_153);
        st_next[8].mp = mp_prod[ucal_pkg::SH_153 +: 4];
    end

    // C10: calendar fields
    always_comb
    begin
        dom_full = st_reg[8].doy - ucal_pkg::month_start(st_reg[8].mp) + 9'd1;
        if (st_reg[8].mp < 4'd10)
        begin
            mon = st_reg[8].mp + 4'd3;
        end
        else
        begin
            mon = st_reg[8].mp - 4'd9;
        end
        year_full = 13'(st_reg[8].era) * ucal_pkg::YEARS_ERA - ucal_pkg::YEARS_ERA
                  + 13'(st_reg[8].yoe) + 13'(mon <= 4'd2);
        date_next.weekday      = st_reg[8].wd;
        date_next.day_of_month = dom_full[4:0];
        date_next.month        = mon;
        date_next.year         = year_full[11:0];
    end

    // Control travels with the word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ucal_pkg::CIVIL_LAT; i++)
            begin
                ctl_reg[i] <= '0;
            end
        end
        else
        begin
            ctl_reg[0] <= ctl_in;
            for (int i = 1; i < ucal_pkg::CIVIL_LAT; i++)
            begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NST; i++)
        begin
            st_reg[i] <= st_next[i];
        end
        date_reg <= date_next;
    end

    assign ctl_out = ctl_reg[ucal_pkg::CIVIL_LAT-1];
    assign date    = date_reg;

endmodule

FILE: sv/unix_seconds_to_calendar.sv
// Throughput: one word per cycle; busy is low once its register has been clocked out of reset.
// Depth: three split stages, ten date stages and the output register.
// Reset clears every valid bit except valid_res and holds busy high; nothing else needs clearing.
// Results are strobed by done for one cycle; the receiver cannot stall.
`include "unix_seconds_to_calendar_defines.svh"

module unix_seconds_to_calendar #(
    parameter int TIME_WIDTH = 40
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [TIME_WIDTH-1:0] epoch_secs,
    output logic                  done,
    output logic                  valid_res,
    output logic [5:0]            second,
    output logic [5:0]            minute,
    output logic [4:0]            hour,
    output logic [2:0]            weekday,
    output logic [4:0]            day_of_month,
    output logic [3:0]            month,
    output logic [11:0]           year
);

    localparam int PAD = ucal_pkg::TOD_PAD;

    logic                         busy_reg;
    logic                         in_valid;
    ucal_pkg::ucal_ctl_t          split_ctl;
    logic [ucal_pkg::DAY_W-1:0]   split_day;
    logic [ucal_pkg::SOD_W-1:0]   split_sod;
    logic                         tod_valid;
    ucal_pkg::ucal_tod_t          tod;
    ucal_pkg::ucal_ctl_t          civ_ctl;
    ucal_pkg::ucal_date_t         civ_date;
    logic [PAD-1:0]               pad_valid_reg;
    ucal_pkg::ucal_tod_t          pad_tod_reg [PAD];

    logic                         done_reg;
    logic                         valid_res_reg;
    ucal_pkg::ucal_tod_t          tod_out_reg;
    ucal_pkg::ucal_tod_t          tod_out_next;
    ucal_pkg::ucal_date_t         date_out_reg;
    ucal_pkg::ucal_date_t         date_out_next;

    logic                         fields_zero;
    logic                         fields_legal;

    assign in_valid = start && !busy_reg;

    ucal_split #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_split (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .epoch_secs   (epoch_secs),
        .ctl          (split_ctl),
        .day          (split_day),
        .sod          (split_sod)
    );

    ucal_tod u_tod (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (split_ctl.valid),
        .sod       (split_sod),
        .out_valid (tod_valid),
        .tod       (tod)
    );

    ucal_civil u_civil (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (split_ctl),
        .day     (split_day),
        .ctl_out (civ_ctl),
        .date    (civ_date)
    );

    // Busy only while in reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
        end
    end

    // Delay time of day to line up with the date path
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_valid_reg <= '0;
        end
        else
        begin
            pad_valid_reg <= {pad_valid_reg[PAD-2:0], tod_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        pad_tod_reg[0] <= tod;
        for (int i = 1; i < PAD; i++)
        begin
            pad_tod_reg[i] <= pad_tod_reg[i-1];
        end
    end

    // Output word: zero everything outside years 0..4095
    always_comb
    begin
        if (civ_ctl.in_range)
        begin
            tod_out_next  = pad_tod_reg[PAD-1];
            date_out_next = civ_date;
        end
        else
        begin
            tod_out_next  = '0;
            date_out_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= civ_ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        valid_res_reg <= civ_ctl.in_range;
        tod_out_reg   <= tod_out_next;
        date_out_reg  <= date_out_next;
    end

    assign busy         = busy_reg;
    assign done         = done_reg;
    assign valid_res    = valid_res_reg;
    assign second       = tod_out_reg.second;
    assign minute       = tod_out_reg.minute;
    assign hour         = tod_out_reg.hour;
    assign weekday      = date_out_reg.weekday;
    assign day_of_month = date_out_reg.day_of_month;
    assign month        = date_out_reg.month;
    assign year         = date_out_reg.year;

    // Field checks on the result word
    assign fields_zero  = (year == 12'd0) && (month == 4'd0) && (day_of_month == 5'd0) &&
                          (weekday == 3'd0) && (hour == 5'd0) && (minute == 6'd0) &&
                          (second == 6'd0);
    assign fields_legal = (month >= 4'd1) && (month <= 4'd12) && (day_of_month >= 5'd1) &&
                          (weekday <= 3'd6) && (hour <= 5'd23) && (minute <= 6'd59) &&
                          (second <= 6'd59);

    // Checks
    `UCAL_ASSERT_DELAY(a_word_latency, in_valid, ucal_pkg::TOTAL_LAT, done, "accepted word lost")
    `UCAL_ASSERT_IMPL(a_no_spurious, done, $past(in_valid, ucal_pkg::TOTAL_LAT), "stray result")
    `UCAL_ASSERT_IMPL(a_paths_aligned, civ_ctl.valid, pad_valid_reg[PAD-1], "paths out of step")
    `UCAL_ASSERT_IMPL(a_invalid_zero, done && !valid_res, fields_zero, "invalid result not zeroed")
    `UCAL_ASSERT_IMPL(a_fields_legal, done && valid_res, fields_legal, "field out of range")

endmodule
